// ----- hw/rtl/sarc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, sizes and codes of the sorted array rank counter
// no dependencies; used by the interfaces and every module

package sarc_pkg;

	// store geometry
	localparam int MAX_ELEMENTS = 1024;
	localparam int KEY_BITS     = 64;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int RANK_W       = $clog2(MAX_ELEMENTS + 1);

	// fixed field widths at the ports
	localparam int INDEX_W  = 10;
	localparam int KEY_IN_W = 64;
	localparam int CNT_W    = 11;

	// search slots: strict (lower bound) and inclusive (upper bound)
	localparam int SRCH_LT = 0;
	localparam int SRCH_LE = 1;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [RANK_W-1:0]   rank_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [INDEX_W-1:0]  index_t;
	typedef logic [KEY_IN_W-1:0] key_in_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_SEARCH,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} rd_req_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		key_t  data;
	} wr_req_t;

	typedef struct packed {
		logic  start;
		key_t  pivot;
		rank_t n;
	} seq_cmd_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		rank_t rank_lt;
		rank_t rank_le;
	} seq_rsp_t;

endpackage

// ----- hw/rtl/sarc_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces: configuration, input items, results
// depends on sarc_pkg

interface sarc_cfg_if import sarc_pkg::*; ();
	logic valid;
	logic ready;
	cnt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sarc_in_if import sarc_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    operation;
	index_t  index;
	key_in_t key;

	modport source (output valid, output operation, output index, output key, input ready);
	modport sink (input valid, input operation, input index, input key, output ready);
endinterface

interface sarc_out_if import sarc_pkg::*; ();
	logic valid;
	logic ready;
	cnt_t count_less;
	cnt_t count_less_equal;

	modport source (output valid, output count_less, output count_less_equal, input ready);
	modport sink (input valid, input count_less, input count_less_equal, output ready);
endinterface

// ----- hw/rtl/sarc_key_mem.sv -----
`timescale 1ns / 1ps
// key store: one write port, one read port with registered read data
// depends on sarc_pkg

module sarc_key_mem import sarc_pkg::*; (
	input  logic    clk,
	input  wr_req_t wr,
	input  rd_req_t rd,
	output key_t    rd_data
);

	key_t mem_q [MAX_ELEMENTS];
	key_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/sarc_search_seq.sv -----
`timescale 1ns / 1ps
// search sequencer: end checks, then two interleaved binary searches that
// share one key comparator and the store read port; depends on sarc_pkg

module sarc_search_seq import sarc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  seq_cmd_t cmd,
	input  logic     out_free,
	input  key_t     rd_data,
	output rd_req_t  rd,
	output seq_rsp_t rsp
);

	seq_state_t state_q, state_d;
	key_t       pivot_q;
	rank_t      n_q;
	addr_t      lo_q [2];
	addr_t      hi_q [2];
	rank_t      res_q [2];
	logic [1:0] res_vld_q;
	logic       probe_vld_s1;
	logic       probe_sel_s1;
	addr_t      mid_s1;

	logic       key_lt, key_eq;
	logic [1:0] go_right;
	logic [1:0] live, in_flight, elig, finish;
	addr_t      mid [2];
	addr_t      last_addr;
	logic       issue, issue_sel;
	addr_t      issue_mid;
	logic [1:0] res_set;
	rank_t      res_val [2];

	// shared comparator
	assign key_lt = rd_data < pivot_q;
	assign key_eq = rd_data == pivot_q;
	assign go_right[SRCH_LT] = key_lt;
	assign go_right[SRCH_LE] = key_lt | key_eq;

	assign last_addr = addr_t'(n_q - rank_t'(1));

	always_comb begin
		for (int x = 0; x < 2; x++) begin
			live[x]      = !res_vld_q[x] &&
				((ADDR_W+1)'(hi_q[x]) > (ADDR_W+1)'(lo_q[x]) + (ADDR_W+1)'(1));
			in_flight[x] = probe_vld_s1 && (probe_sel_s1 == 1'(x));
			elig[x]      = (state_q == ST_SEARCH) && live[x] && !in_flight[x];
			finish[x]    = (state_q == ST_SEARCH) && !res_vld_q[x] && !live[x] &&
				!in_flight[x];
			// upper midpoint
			mid[x] = addr_t'((ADDR_W+1)'(lo_q[x]) +
				(((ADDR_W+1)'(hi_q[x]) - (ADDR_W+1)'(lo_q[x]) + (ADDR_W+1)'(1)) >> 1));
		end
	end

	assign issue     = elig[0] | elig[1];
	assign issue_sel = !elig[0];
	assign issue_mid = mid[issue_sel];

	// result capture per search slot
	always_comb begin
		res_set = '0;
		for (int x = 0; x < 2; x++) begin
			res_val[x] = '0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start && cmd.n == '0) begin
					res_set = 2'b11;
				end
			end
			ST_RD_LAST: begin
				for (int x = 0; x < 2; x++) begin
					res_set[x] = !go_right[x];
				end
			end
			ST_CHK_LAST: begin
				for (int x = 0; x < 2; x++) begin
					res_set[x] = !res_vld_q[x] && go_right[x];
					res_val[x] = n_q;
				end
			end
			ST_SEARCH: begin
				for (int x = 0; x < 2; x++) begin
					res_set[x] = finish[x];
					res_val[x] = rank_t'(lo_q[x]) + rank_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = (cmd.n == '0) ? ST_OUT : ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: state_d = ST_RD_LAST;
			ST_RD_LAST:  state_d = ST_CHK_LAST;
			ST_CHK_LAST: state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (&res_vld_q) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd.en   = 1'b0;
		rd.addr = '0;
		unique case (state_q)
			ST_RD_FIRST: begin
				rd.en = 1'b1;
			end
			ST_RD_LAST: begin
				rd.en   = 1'b1;
				rd.addr = last_addr;
			end
			ST_SEARCH: begin
				rd.en   = issue;
				rd.addr = issue_mid;
			end
			default: begin
			end
		endcase
		rsp.busy    = state_q != ST_IDLE;
		rsp.done    = state_q == ST_OUT;
		rsp.rank_lt = res_q[SRCH_LT];
		rsp.rank_le = res_q[SRCH_LE];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_vld_q    <= '0;
			probe_vld_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			probe_vld_s1 <= issue;
			if (state_q == ST_IDLE && cmd.start) begin
				res_vld_q <= res_set;
			end else begin
				res_vld_q <= res_vld_q | res_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.start) begin
			pivot_q <= cmd.pivot;
			n_q     <= cmd.n;
		end
		for (int x = 0; x < 2; x++) begin
			if (res_set[x]) begin
				res_q[x] <= res_val[x];
			end
		end
		if (state_q == ST_CHK_LAST) begin
			for (int x = 0; x < 2; x++) begin
				lo_q[x] <= '0;
				hi_q[x] <= last_addr;
			end
		end
		if (probe_vld_s1) begin
			if (go_right[probe_sel_s1]) begin
				lo_q[probe_sel_s1] <= mid_s1;
			end else begin
				hi_q[probe_sel_s1] <= mid_s1;
			end
		end
		if (issue) begin
			probe_sel_s1 <= issue_sel;
			mid_s1       <= issue_mid;
		end
	end

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_OUT) |-> !rd.en)
		else $error("store read outside a search");

	a_probe_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		probe_vld_s1 |-> state_q == ST_SEARCH)
		else $error("probe in flight outside search state");

	a_slots_alternate: assert property (@(posedge clk) disable iff (!arst_n)
		(probe_vld_s1 && issue) |-> issue_sel != probe_sel_s1)
		else $error("search slot probed twice in a row");

	a_ranks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> (res_vld_q == 2'b11 && res_q[SRCH_LT] <= n_q &&
		res_q[SRCH_LE] <= n_q))
		else $error("result out of range or incomplete");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT &&
		$stable(res_q[SRCH_LT]) && $stable(res_q[SRCH_LE])))
		else $error("pending result changed");

endmodule

// ----- hw/rtl/sorted_array_rank_counter_unit.sv -----
`timescale 1ns / 1ps
// top level of the sorted array rank counter: ports, count register,
// result register; depends on sarc_pkg, sarc_if, sarc_key_mem, sarc_search_seq
//
// usage
// - cfg: one register, element_count (keys in use); always ready, write it
//   only while the block is idle; values above the store depth act as full
// - items: operation write puts key at index (no result; an index
//   beyond the store is dropped); operation query takes key as pivot
// - results: one transaction per query, count_less (keys below the pivot)
//   and count_less_equal (keys at or below it), over the first
//   element_count entries, which software keeps ascending and has written
// - a query reads the first and the last entry; where these end entries settle
//   both counts no probe follows, else two binary searches run; the one store
//   read port and the shared comparator are used in turn by the two searches;
//   an empty store goes straight to the result without a read
// - items.ready is low from a query until its result is registered; a write does not lower it
// - a finished result sits in the output register; the next item is taken
//   while it waits, and a query that finishes while the register is still
//   full holds until results.ready frees it
// - reset clears the count register and all control state; the store is
//   not cleared and needs no sweep

module sorted_array_rank_counter_unit import sarc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sarc_cfg_if.sink          cfg,
	sarc_in_if.sink           items,
	sarc_out_if.source        results
);

	cnt_t     element_count_q;
	logic     in_accept;
	logic     out_free;
	logic     out_vld_q;
	cnt_t     out_lt_q;
	cnt_t     out_le_q;
	wr_req_t  wr;
	rd_req_t  rd;
	key_t     rd_data;
	seq_cmd_t cmd;
	seq_rsp_t rsp;

	// configuration register, always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			element_count_q <= cfg.data;
		end
	end

	// input side: not ready while the sequencer works on a query
	assign items.ready = !rsp.busy;
	assign in_accept   = items.valid && items.ready;

	// store write straight from the accepted transaction
	assign wr.en   = in_accept && (op_t'(items.operation) == OP_WRITE) &&
		(32'(items.index) < 32'(MAX_ELEMENTS));
	assign wr.addr = addr_t'(items.index);
	assign wr.data = key_t'(items.key);

	// query start with pivot and saturated key count
	always_comb begin
		cmd.start = in_accept && (op_t'(items.operation) == OP_QUERY);
		cmd.pivot = key_t'(items.key);
		if (32'(element_count_q) > 32'(MAX_ELEMENTS)) begin
			cmd.n = rank_t'(MAX_ELEMENTS);
		end else begin
			cmd.n = rank_t'(element_count_q);
		end
	end

	sarc_key_mem u_key_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	sarc_search_seq u_search_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_free (out_free),
		.rd_data  (rd_data),
		.rd       (rd),
		.rsp      (rsp)
	);

	// output register, free when empty or drained this cycle
	assign out_free = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= rsp.done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && rsp.done) begin
			out_lt_q <= cnt_t'(rsp.rank_lt);
			out_le_q <= cnt_t'(rsp.rank_le);
		end
	end

	assign results.valid            = out_vld_q;
	assign results.count_less       = out_lt_q;
	assign results.count_less_equal = out_le_q;

endmodule
